### sv/km2d_pkg.sv
// ----------------------------------------------------------------------------
// km2d_pkg: shared types and constants for the 2-D k-means block
// Field widths, payload structs and opcode/result codes.
// ----------------------------------------------------------------------------
package km2d_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_POINTS   = 4096;
    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 8;
    localparam int FX_BITS      = COORD_BITS + FRAC_BITS;
    localparam int IDX_BITS     = $clog2(MAX_CLUSTERS);
    localparam int CNT_BITS     = $clog2(MAX_POINTS + 1);
    localparam int SUM_BITS     = COORD_BITS + $clog2(MAX_POINTS);
    localparam int KCFG_BITS    = 5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [3:0]            centroid_slot;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  end_of_pass;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [3:0]         cluster_index;
        logic [FX_BITS-1:0] centroid_x;
        logic [FX_BITS-1:0] centroid_y;
        logic [12:0]        member_total;
        logic               converged;
        logic               count_overflow;
        logic               last_result;
    } t_out_item;

endpackage

### sv/kmeans_2d_assign_update.sv
// ----------------------------------------------------------------------------
// kmeans_2d_assign_update: one Lloyd k-means pass over 2-D points
// Nearest-centroid assignment with running sums, and a centroid report with
// restoring division at end of pass.
// ----------------------------------------------------------------------------
// channel | direction | payload
// i_in    | in        | t_in_item   (i_in_valid / o_in_ready)
// o_out   | out       | t_out_item  (o_out_valid / i_out_ready)
// i_cfg   | in        | cluster_count (i_cfg_valid / o_cfg_ready)
//
// A load writes one centroid slot. For a point, one shared distance unit
// (two squarers and an add) visits one centroid per cycle. End of pass adds,
// per non-empty cluster, two 33-step restoring divisions on one shared
// subtractor (an empty cluster skips them), then one report transfer per
// cluster and a wrap state that closes the pass. Reset is synchronous; the
// centroid, sum and count tables clear at reset (16 entries, valid-free).
// A stalled output holds the sequencer; input is not ready meanwhile.
// ----------------------------------------------------------------------------
module kmeans_2d_assign_update (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  km2d_pkg::t_in_item       i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output km2d_pkg::t_out_item      o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [4:0]               i_cfg
);
    localparam int FXB = km2d_pkg::FX_BITS;
    localparam int IB  = km2d_pkg::IDX_BITS;
    localparam int CB  = km2d_pkg::CNT_BITS;
    localparam int SB  = km2d_pkg::SUM_BITS;
    localparam int NB  = SB + km2d_pkg::FRAC_BITS + 1;
    localparam int DB  = 2 * FXB + 1;
    localparam int STB = $clog2(NB + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_ACC, S_OUT, S_RSTART, S_DIVX, S_DIVY, S_RSEND, S_WRAP
    } t_state;

    t_state r_state;
    logic [FXB-1:0] r_cx [km2d_pkg::MAX_CLUSTERS];
    logic [FXB-1:0] r_cy [km2d_pkg::MAX_CLUSTERS];
    logic [FXB-1:0] r_nx [km2d_pkg::MAX_CLUSTERS];
    logic [FXB-1:0] r_ny [km2d_pkg::MAX_CLUSTERS];
    logic [SB-1:0]  r_sx [km2d_pkg::MAX_CLUSTERS];
    logic [SB-1:0]  r_sy [km2d_pkg::MAX_CLUSTERS];
    logic [CB-1:0]  r_cnt [km2d_pkg::MAX_CLUSTERS];
    logic r_ovf, r_conv, r_eop;
    logic [4:0] r_kcfg;
    logic [km2d_pkg::COORD_BITS-1:0] r_px, r_py;
    logic [IB:0] r_i;
    logic [IB-1:0] r_best;
    logic [DB-1:0] r_bestd;
    logic [NB-1:0] r_num, r_quo;
    logic [CB:0] r_rem;
    logic [STB-1:0] r_step;
    logic r_ovalid;
    km2d_pkg::t_out_item r_out;

    logic [IB:0] w_k;
    logic [FXB-1:0] w_fx, w_fy, w_dx, w_dy;
    logic [DB-1:0] w_d;
    logic [IB-1:0] w_i;
    logic [CB:0] w_rsh, w_rsub;
    logic [FXB-1:0] w_q;

    always_comb begin
        if (r_kcfg < 5'd2) begin
            w_k = (IB+1)'(2);
        end else if (r_kcfg > 5'(km2d_pkg::MAX_CLUSTERS)) begin
            w_k = (IB+1)'(km2d_pkg::MAX_CLUSTERS);
        end else begin
            w_k = r_kcfg[IB:0];
        end
        w_i  = r_i[IB-1:0];
        w_fx = {r_px, km2d_pkg::FRAC_BITS'(0)};
        w_fy = {r_py, km2d_pkg::FRAC_BITS'(0)};
        w_dx = (w_fx > r_cx[w_i]) ? w_fx - r_cx[w_i] : r_cx[w_i] - w_fx;
        w_dy = (w_fy > r_cy[w_i]) ? w_fy - r_cy[w_i] : r_cy[w_i] - w_fy;
        w_d  = DB'(w_dx * w_dx) + DB'(w_dy * w_dy);
        w_rsh  = {r_rem[CB-1:0], r_num[NB-1]};
        w_rsub = w_rsh - (CB+1)'(r_cnt[w_i]);
        w_q    = r_quo[FXB-1:0];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kcfg   <= 5'd2;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            for (int j = 0; j < km2d_pkg::MAX_CLUSTERS; j++) begin
                r_cx[j]  <= '0;
                r_cy[j]  <= '0;
                r_sx[j]  <= '0;
                r_sy[j]  <= '0;
                r_cnt[j] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_kcfg <= i_cfg;
                    end
                    if (i_in_valid) begin
                        r_px  <= i_in.point_x;
                        r_py  <= i_in.point_y;
                        r_eop <= i_in.end_of_pass;
                        r_i   <= '0;
                        if (i_in.opcode == km2d_pkg::OP_LOAD) begin
                            r_cx[i_in.centroid_slot[IB-1:0]] <=
                                {i_in.point_x, km2d_pkg::FRAC_BITS'(0)};
                            r_cy[i_in.centroid_slot[IB-1:0]] <=
                                {i_in.point_y, km2d_pkg::FRAC_BITS'(0)};
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_DIST: begin
                    if (r_i == '0 || w_d < r_bestd) begin
                        r_bestd <= w_d;
                        r_best  <= w_i;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == w_k) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_cnt[r_best] >= CB'(km2d_pkg::MAX_POINTS)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_sx[r_best]  <= r_sx[r_best] + SB'(r_px);
                        r_sy[r_best]  <= r_sy[r_best] + SB'(r_py);
                        r_cnt[r_best] <= r_cnt[r_best] + 1'b1;
                    end
                    r_out.result_kind    <= km2d_pkg::KIND_ASSIGN;
                    r_out.cluster_index  <= 4'(r_best);
                    r_out.centroid_x     <= '0;
                    r_out.centroid_y     <= '0;
                    r_out.member_total   <= '0;
                    r_out.converged      <= 1'b0;
                    r_out.count_overflow <= 1'b0;
                    r_out.last_result    <= !r_eop;
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (r_ovalid && i_out_ready) begin
                        r_ovalid <= 1'b0;
                        r_i    <= '0;
                        r_conv <= 1'b1;
                        r_state <= r_eop ? S_RSTART : S_IDLE;
                    end
                end
                S_RSTART: begin
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_step <= '0;
                    if (r_i == w_k) begin
                        r_i     <= '0;
                        r_state <= S_RSEND;
                    end else if (r_cnt[w_i] == '0) begin
                        r_nx[w_i] <= r_cx[w_i];
                        r_ny[w_i] <= r_cy[w_i];
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_num <= NB'({r_sx[w_i], km2d_pkg::FRAC_BITS'(0)})
                                 + NB'(r_cnt[w_i] >> 1);
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX, S_DIVY: begin
                    if (r_step == STB'(NB)) begin
                        r_step <= '0;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        if (r_state == S_DIVX) begin
                            r_nx[w_i] <= w_q;
                            if (w_q != r_cx[w_i]) r_conv <= 1'b0;
                            r_num <= NB'({r_sy[w_i], km2d_pkg::FRAC_BITS'(0)})
                                     + NB'(r_cnt[w_i] >> 1);
                            r_state <= S_DIVY;
                        end else begin
                            r_ny[w_i] <= w_q;
                            if (w_q != r_cy[w_i]) r_conv <= 1'b0;
                            r_i <= r_i + 1'b1;
                            r_state <= S_RSTART;
                        end
                    end else begin
                        r_num  <= r_num << 1;
                        r_step <= r_step + 1'b1;
                        if (!w_rsub[CB]) begin
                            r_rem <= w_rsub;
                            r_quo <= {r_quo[NB-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_quo <= {r_quo[NB-2:0], 1'b0};
                        end
                    end
                end
                S_RSEND: begin
                    if (!r_ovalid || i_out_ready) begin
                        if (r_i == w_k) begin
                            r_ovalid <= 1'b0;
                            r_state  <= S_WRAP;
                        end else begin
                            r_out.result_kind    <= km2d_pkg::KIND_REPORT;
                            r_out.cluster_index  <= 4'(w_i);
                            r_out.centroid_x     <= r_nx[w_i];
                            r_out.centroid_y     <= r_ny[w_i];
                            r_out.member_total   <= 13'(r_cnt[w_i]);
                            r_out.converged      <= r_conv;
                            r_out.count_overflow <= r_ovf;
                            r_out.last_result    <= (r_i + 1'b1 == w_k);
                            r_ovalid <= 1'b1;
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_WRAP: begin
                    if (!r_ovalid || i_out_ready) begin
                        for (int j = 0; j < km2d_pkg::MAX_CLUSTERS; j++) begin
                            if (j < int'(w_k)) begin
                                r_cx[j] <= r_nx[j];
                                r_cy[j] <= r_ny[j];
                            end
                            r_sx[j]  <= '0;
                            r_sy[j]  <= '0;
                            r_cnt[j] <= '0;
                        end
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
